// ===== rtl/deq_pkg.sv =====
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 8;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    FN_PUSH_REAR  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_REAR   = 3'd3,
    FN_CLEAR      = 3'd4,
    FN_LENGTH     = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // one-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_rear;
    logic pop_rear;
    logic clear_all;
  } cell_ctl_t;

endpackage

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of deq_pkg::DEPTH entries. Each request (start
// high while busy is low) names one operation: push rear, push front, pop
// front, pop rear, clear or length query; codes 6 and 7 act as a length
// query. Every request returns exactly one result in the next cycle, marked by
// done for a single cycle; the receiver cannot stall, so capture it then.
// busy never rises: a request may be issued in every cycle, one result per
// cycle. The entries live in a row of cells, front at cell 0; pushes and
// pops at the front shift the whole row one place, while rear operations
// touch only the cell at the boundary of the held entries.
// A push to a full queue returns status full, a pop from an empty queue
// returns data_out zero with status empty; neither changes the state.
module double_ended_queue (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       func,
  input  logic [deq_pkg::DATA_WIDTH-1:0]   data_in,
  output logic                             done,
  output logic [deq_pkg::DATA_WIDTH-1:0]   data_out,
  output logic [1:0]                       status,
  output logic [deq_pkg::CNT_W-1:0]        count,
  output logic                             is_empty
);

  localparam logic [deq_pkg::CNT_W-1:0] FULL_CNT = deq_pkg::CNT_W'(deq_pkg::DEPTH);

  logic [deq_pkg::CNT_W-1:0]      fill;
  logic [deq_pkg::CNT_W-1:0]      fill_next;
  logic                           full;
  logic                           empty;
  logic                           accept;
  deq_pkg::func_t                 fn;
  deq_pkg::cell_ctl_t             ctl;
  deq_pkg::status_t               status_next;
  logic [deq_pkg::DATA_WIDTH-1:0] data_next;

  logic [deq_pkg::DATA_WIDTH-1:0] cell_data  [deq_pkg::DEPTH];
  logic                           cell_occ   [deq_pkg::DEPTH];
  logic [deq_pkg::DATA_WIDTH-1:0] rear_chain [deq_pkg::DEPTH+1];

  // one request per cycle, always
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign fn     = deq_pkg::func_t'(func);
  assign full   = (fill == FULL_CNT);
  assign empty  = (fill == '0);

  // decode the request into a row command; refused pushes and pops drop out here
  always_comb begin
    ctl         = '0;
    fill_next   = fill;
    status_next = deq_pkg::ST_OK;
    data_next   = '0;
    unique case (fn)
      deq_pkg::FN_PUSH_REAR, deq_pkg::FN_PUSH_FRONT: begin
        if (full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          ctl.push_rear  = (fn == deq_pkg::FN_PUSH_REAR);
          ctl.push_front = (fn == deq_pkg::FN_PUSH_FRONT);
          fill_next      = fill + 1'b1;
        end
      end
      deq_pkg::FN_POP_FRONT, deq_pkg::FN_POP_REAR: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          ctl.pop_front = (fn == deq_pkg::FN_POP_FRONT);
          ctl.pop_rear  = (fn == deq_pkg::FN_POP_REAR);
          data_next     = (fn == deq_pkg::FN_POP_FRONT) ? cell_data[0]
                                                        : rear_chain[deq_pkg::DEPTH];
          fill_next     = fill - 1'b1;
        end
      end
      deq_pkg::FN_CLEAR: begin
        ctl.clear_all = 1'b1;
        fill_next     = '0;
      end
      default: begin
        // length query and the unused codes: leave the state alone
      end
    endcase
    if (!accept) begin
      ctl       = '0;
      fill_next = fill;
    end
  end

  // the row of cells; the rear value ripples along rear_chain
  assign rear_chain[0] = '0;

  for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
    logic [deq_pkg::DATA_WIDTH-1:0] ld;
    logic                           lo;
    logic [deq_pkg::DATA_WIDTH-1:0] rd;
    logic                           ro;

    if (i == 0) begin : g_first
      // the front of the row sees the pushed value and counts as held
      assign ld = data_in;
      assign lo = 1'b1;
    end else begin : g_mid
      assign ld = cell_data[i-1];
      assign lo = cell_occ[i-1];
    end

    if (i == deq_pkg::DEPTH - 1) begin : g_last
      assign rd = '0;
      assign ro = 1'b0;
    end else begin : g_inner
      assign rd = cell_data[i+1];
      assign ro = cell_occ[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .push_data  (data_in),
      .left_data  (ld),
      .left_occ   (lo),
      .right_data (rd),
      .right_occ  (ro),
      .rear_in    (rear_chain[i]),
      .data_q     (cell_data[i]),
      .occ        (cell_occ[i]),
      .rear_out   (rear_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      done <= 1'b0;
    end else begin
      fill <= fill_next;
      done <= accept;
    end
  end

  // register the result; it holds until the next accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      data_out <= data_next;
      status   <= status_next;
      count    <= fill_next;
      is_empty <= (fill_next == '0);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_CNT)
    else $error("entry count beyond depth");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("request without result strobe");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (count == fill) && (is_empty == (fill == '0)))
    else $error("reported count disagrees with held count");

  a_front_occ: assert property (@(posedge clk) disable iff (rst)
    cell_occ[0] == !empty)
    else $error("front cell occupancy disagrees with count");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != deq_pkg::ST_OK) |-> (data_out == '0))
    else $error("refused request returned data");

endmodule

// ===== rtl/deq_cell.sv =====
module deq_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  deq_pkg::cell_ctl_t               ctl,
  input  logic [deq_pkg::DATA_WIDTH-1:0]   push_data,
  input  logic [deq_pkg::DATA_WIDTH-1:0]   left_data,
  input  logic                             left_occ,
  input  logic [deq_pkg::DATA_WIDTH-1:0]   right_data,
  input  logic                             right_occ,
  input  logic [deq_pkg::DATA_WIDTH-1:0]   rear_in,
  output logic [deq_pkg::DATA_WIDTH-1:0]   data_q,
  output logic                             occ,
  output logic [deq_pkg::DATA_WIDTH-1:0]   rear_out
);

  logic is_rear;
  logic is_slot;

  // rear entry: held here, nothing held to the right
  assign is_rear  = occ && !right_occ;
  // first free slot: empty here, held (or the row's start) to the left
  assign is_slot  = !occ && left_occ;
  assign rear_out = rear_in | (data_q & {deq_pkg::DATA_WIDTH{is_rear}});

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.clear_all) begin
      occ <= 1'b0;
    end else if (ctl.push_front) begin
      occ <= left_occ;
    end else if (ctl.pop_front) begin
      occ <= right_occ;
    end else if (ctl.push_rear && is_slot) begin
      occ <= 1'b1;
    end else if (ctl.pop_rear && is_rear) begin
      occ <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push_front) begin
      data_q <= left_data;
    end else if (ctl.pop_front) begin
      data_q <= right_data;
    end else if (ctl.push_rear && is_slot) begin
      data_q <= push_data;
    end
  end

endmodule
